/* rtl/oscp_pkg.sv */
`default_nettype none

package oscp_pkg;

  // Tags carried in byte_kind.
  localparam logic [2:0] KIND_FLAGS  = 3'd0;
  localparam logic [2:0] KIND_PIV    = 3'd1;
  localparam logic [2:0] KIND_CTXLEN = 3'd2;
  localparam logic [2:0] KIND_CTX    = 3'd3;
  localparam logic [2:0] KIND_KID    = 3'd4;
  localparam logic [2:0] KIND_NONE   = 3'd5;

  // Parser phase codes.
  localparam logic [2:0] PH_FLAGS  = 3'd0;
  localparam logic [2:0] PH_PIV    = 3'd1;
  localparam logic [2:0] PH_CTXLEN = 3'd2;
  localparam logic [2:0] PH_CTX    = 3'd3;
  localparam logic [2:0] PH_KID    = 3'd4;
  localparam logic [2:0] PH_IGNORE = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PIV_MAX = 2'd0;
  localparam logic [1:0] CFG_KID_MAX = 2'd1;
  localparam logic [1:0] CFG_CTX_MAX = 2'd2;

  // Flags byte fields.
  localparam logic [7:0] FLAG_RESERVED = 8'h80;
  localparam logic [7:0] FLAG_CONTEXT  = 8'h10;
  localparam logic [7:0] FLAG_KID      = 8'h08;
  localparam logic [7:0] FLAG_PIV_LEN  = 8'h07;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
    logic       empty_option;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
    logic [7:0] field_index;
    logic       option_done;
    logic       status;
    logic       has_piv;
    logic [2:0] piv_len;
    logic       has_context;
    logic [7:0] context_len;
    logic       has_kid;
    logic [7:0] kid_len;
  } out_t;

  typedef struct packed {
    logic [2:0] piv_max_len;
    logic [7:0] kid_max_len;
    logic [7:0] context_max_len;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/oscore_option_parser.sv */
// OSCORE option value parser.
// Input channel (in_valid/in_ready/in_data) carries one option byte per
// request, with last_byte marking the end of the option and empty_option
// standing for a zero-length option. The result channel (out_valid/out_ready/
// out_data) returns exactly one result per request: the byte, its field tag
// and index, and on the final byte the status, presence flags and lengths.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the
// PIV, KID and KID context length limits; write it only while the parser is
// idle. Indexes beyond the register list are accepted and dropped.
// A request passes one input register, then the parse logic feeding the
// result register. Throughput is one request per cycle while out_ready
// stays high; the parser state updates once per processed request.
// When out_ready is low the result register holds its request, the input
// register still takes one more request, and in_ready then drops until the
// result is taken. Synchronous reset clears the pipeline, the parser state
// and restores the limits to 5, 16 and 16; all ready outputs are low while
// reset is asserted.
`default_nettype none

module oscore_option_parser #(
  parameter int LEN_BITS = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  oscp_pkg::in_t        in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output oscp_pkg::out_t       out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [1:0]           cfg_index,
  input  wire  [7:0]           cfg_data
);

  oscp_pkg::in_t  in_r;
  logic           in_v_r;
  oscp_pkg::out_t out_r;
  oscp_pkg::out_t result;
  logic           out_v_r;
  logic           advance;
  oscp_pkg::cfg_t cfg_r;

  // Pipeline flow control.
  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = rst_n && (!in_v_r || advance);
  assign cfg_ready = rst_n;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  // Limit registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.piv_max_len     <= 3'd5;
      cfg_r.kid_max_len     <= 8'd16;
      cfg_r.context_max_len <= 8'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        oscp_pkg::CFG_PIV_MAX: cfg_r.piv_max_len     <= cfg_data[2:0];
        oscp_pkg::CFG_KID_MAX: cfg_r.kid_max_len     <= cfg_data;
        oscp_pkg::CFG_CTX_MAX: cfg_r.context_max_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  oscp_parse #(
    .LEN_BITS (LEN_BITS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_r),
    .cfg     (cfg_r),
    .result  (result)
  );

endmodule

`default_nettype wire

/* rtl/oscp_parse.sv */
`default_nettype none

module oscp_parse #(
  parameter int LEN_BITS = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  advance,
  input  oscp_pkg::in_t        item,
  input  oscp_pkg::cfg_t       cfg,
  output oscp_pkg::out_t       result
);

  // Compare width covers both the counters and the 8-bit limits.
  localparam int CW = (LEN_BITS > 8) ? LEN_BITS : 8;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  logic [2:0]          phase_r, phase_nxt;
  logic [LEN_BITS-1:0] field_count_r, field_count_nxt;
  logic [2:0]          piv_expected_r, piv_expected_nxt;
  logic                context_flag_r, context_flag_nxt;
  logic                kid_flag_r, kid_flag_nxt;
  logic [7:0]          context_expected_r, context_expected_nxt;
  logic [LEN_BITS-1:0] kid_count_r, kid_count_nxt;
  logic                error_seen_r, error_seen_nxt;

  // Values after the current byte, before the end-of-option clear.
  logic [2:0]          phase_p;
  logic [LEN_BITS-1:0] field_count_p;
  logic [2:0]          piv_expected_p;
  logic                context_flag_p;
  logic                kid_flag_p;
  logic [7:0]          context_expected_p;
  logic [LEN_BITS-1:0] kid_count_p;
  logic                error_seen_p;

  logic [LEN_BITS-1:0] fc_inc;
  logic [LEN_BITS-1:0] idx;
  logic [2:0]          kind;
  logic [7:0]          b;
  logic                done;
  logic                bad;
  logic [CW-1:0]       idx_w;
  logic [CW-1:0]       kid_w;

  assign b      = item.in_byte;
  assign done   = item.last_byte | item.empty_option;
  assign fc_inc = (field_count_r != LEN_MAX) ? field_count_r + 1'b1 : field_count_r;

  // Per-byte phase update.
  always_comb begin
    phase_p            = phase_r;
    field_count_p      = field_count_r;
    piv_expected_p     = piv_expected_r;
    context_flag_p     = context_flag_r;
    kid_flag_p         = kid_flag_r;
    context_expected_p = context_expected_r;
    kid_count_p        = kid_count_r;
    error_seen_p       = error_seen_r;
    kind               = oscp_pkg::KIND_NONE;
    idx                = '0;
    if (!item.empty_option) begin
      case (phase_r)
        oscp_pkg::PH_FLAGS: begin
          kind           = oscp_pkg::KIND_FLAGS;
          context_flag_p = |(b & oscp_pkg::FLAG_CONTEXT);
          kid_flag_p     = |(b & oscp_pkg::FLAG_KID);
          piv_expected_p = b[2:0] & oscp_pkg::FLAG_PIV_LEN[2:0];
          if ((|(b & oscp_pkg::FLAG_RESERVED)) || (piv_expected_p > cfg.piv_max_len)) begin
            error_seen_p = 1'b1;
            phase_p      = oscp_pkg::PH_IGNORE;
          end else if (piv_expected_p != 3'd0) begin
            phase_p       = oscp_pkg::PH_PIV;
            field_count_p = '0;
          end else begin
            field_count_p = '0;
            phase_p       = context_flag_p ? oscp_pkg::PH_CTXLEN : oscp_pkg::PH_KID;
          end
        end
        oscp_pkg::PH_PIV: begin
          kind          = oscp_pkg::KIND_PIV;
          idx           = field_count_r;
          field_count_p = fc_inc;
          if (CW'(fc_inc) >= CW'(piv_expected_r)) begin
            field_count_p = '0;
            phase_p       = context_flag_r ? oscp_pkg::PH_CTXLEN : oscp_pkg::PH_KID;
          end
        end
        oscp_pkg::PH_CTXLEN: begin
          kind               = oscp_pkg::KIND_CTXLEN;
          context_expected_p = b;
          field_count_p      = '0;
          if (b > cfg.context_max_len) begin
            error_seen_p = 1'b1;
            phase_p      = oscp_pkg::PH_IGNORE;
          end else begin
            phase_p = (b == 8'd0) ? oscp_pkg::PH_KID : oscp_pkg::PH_CTX;
          end
        end
        oscp_pkg::PH_CTX: begin
          kind          = oscp_pkg::KIND_CTX;
          idx           = field_count_r;
          field_count_p = fc_inc;
          if (CW'(fc_inc) >= CW'(context_expected_r)) begin
            phase_p = oscp_pkg::PH_KID;
          end
        end
        oscp_pkg::PH_KID: begin
          if (!kid_flag_r || (CW'(kid_count_r) >= CW'(cfg.kid_max_len))) begin
            error_seen_p = 1'b1;
            phase_p      = oscp_pkg::PH_IGNORE;
          end else begin
            kind        = oscp_pkg::KIND_KID;
            idx         = kid_count_r;
            kid_count_p = (kid_count_r != LEN_MAX) ? kid_count_r + 1'b1 : kid_count_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // End-of-option checks and result fields.
  assign bad = error_seen_p || (phase_p == oscp_pkg::PH_PIV) ||
               (phase_p == oscp_pkg::PH_CTXLEN) || (phase_p == oscp_pkg::PH_CTX) ||
               (phase_p == oscp_pkg::PH_IGNORE);
  assign idx_w = CW'(idx);
  assign kid_w = CW'(kid_count_p);

  always_comb begin
    result             = '0;
    result.out_byte    = item.empty_option ? 8'd0 : b;
    result.byte_kind   = kind;
    result.field_index = idx_w[7:0];
    if (done) begin
      result.option_done = 1'b1;
      result.status      = bad;
      if (!bad) begin
        result.has_piv     = (piv_expected_p != 3'd0);
        result.piv_len     = piv_expected_p;
        result.has_context = context_flag_p;
        result.context_len = context_flag_p ? context_expected_p : 8'd0;
        result.has_kid     = kid_flag_p;
        result.kid_len     = kid_flag_p ? kid_w[7:0] : 8'd0;
      end
    end
  end

  // The state returns to its start values when an option ends.
  always_comb begin
    if (done) begin
      phase_nxt            = oscp_pkg::PH_FLAGS;
      field_count_nxt      = '0;
      piv_expected_nxt     = 3'd0;
      context_flag_nxt     = 1'b0;
      kid_flag_nxt         = 1'b0;
      context_expected_nxt = 8'd0;
      kid_count_nxt        = '0;
      error_seen_nxt       = 1'b0;
    end else begin
      phase_nxt            = phase_p;
      field_count_nxt      = field_count_p;
      piv_expected_nxt     = piv_expected_p;
      context_flag_nxt     = context_flag_p;
      kid_flag_nxt         = kid_flag_p;
      context_expected_nxt = context_expected_p;
      kid_count_nxt        = kid_count_p;
      error_seen_nxt       = error_seen_p;
    end
  end

  // Parser state registers, updated once per processed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= oscp_pkg::PH_FLAGS;
      field_count_r      <= '0;
      piv_expected_r     <= 3'd0;
      context_flag_r     <= 1'b0;
      kid_flag_r         <= 1'b0;
      context_expected_r <= 8'd0;
      kid_count_r        <= '0;
      error_seen_r       <= 1'b0;
    end else if (advance) begin
      phase_r            <= phase_nxt;
      field_count_r      <= field_count_nxt;
      piv_expected_r     <= piv_expected_nxt;
      context_flag_r     <= context_flag_nxt;
      kid_flag_r         <= kid_flag_nxt;
      context_expected_r <= context_expected_nxt;
      kid_count_r        <= kid_count_nxt;
      error_seen_r       <= error_seen_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/oscp_checker.sv */
`default_nettype none

module oscp_checker (
  input wire            clk,
  input wire            rst_n,
  input wire            out_valid,
  input wire            out_ready,
  input oscp_pkg::out_t out_data
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Summary fields stay zero until the option ends.
  a_summary_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.option_done |->
      !out_data.status && !out_data.has_piv && (out_data.piv_len == 3'd0) &&
      !out_data.has_context && (out_data.context_len == 8'd0) &&
      !out_data.has_kid && (out_data.kid_len == 8'd0))
    else $error("summary fields set before option end");

  // A malformed option reports nothing present.
  a_bad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      !out_data.has_piv && !out_data.has_context && !out_data.has_kid &&
      (out_data.piv_len == 3'd0) && (out_data.kid_len == 8'd0))
    else $error("malformed option reports fields");

  // Single-byte fields and untagged bytes have index zero.
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.byte_kind == oscp_pkg::KIND_FLAGS) ||
                  (out_data.byte_kind == oscp_pkg::KIND_CTXLEN) ||
                  (out_data.byte_kind == oscp_pkg::KIND_NONE)) |->
      out_data.field_index == 8'd0)
    else $error("nonzero index on untracked field");

endmodule

bind oscore_option_parser oscp_checker u_oscp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
